@@ hw/rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Sequencer states and configuration register indexes.
// ----------------------------------------------------------------------------
package mexp_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 1'b1;

endpackage

@@ hw/rtl/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises each request base to the configured exponent modulo the configured
// modulus by square and multiply on a chain of modular multiplier cells.
//
//   Channel  Ports                              Direction
//   req      req_valid/req_ready, base_value    in
//   rsp      rsp_valid/rsp_ready, power_result  out
//   csr      csr_write, csr_index, csr_wdata    in
//
// A request takes (VALUE_WIDTH + 1) passes through the VALUE_WIDTH-cell chain.
// The chain holds one multiply pair at a time, so each pass waits for the last.
// The first pass reduces the base; each later pass handles one exponent bit.
// A new request is taken once the previous result is in the output register.
// Reset is synchronous and restores exponent 1 and an all-ones modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [VALUE_WIDTH-1:0]                req_base_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [VALUE_WIDTH-1:0]                rsp_power_result,
   input  logic                                  csr_write,
   input  logic [mexp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [VALUE_WIDTH-1:0]                csr_wdata
);

   localparam int W  = VALUE_WIDTH;
   localparam int PW = $clog2(W + 1);
   localparam int IW = $clog2(W);

   mexp_pkg::state_type state_ff, state_in;

   logic [W-1:0]  exponent_ff;
   logic [W-1:0]  modulus_ff;
   logic [W-1:0]  base_ff;
   logic [W-1:0]  acc_ff;
   logic [W-1:0]  sq_ff;
   logic [PW-1:0] pass_ff;
   logic          launch_ff;
   logic          rsp_valid_ff;
   logic [W-1:0]  rsp_data_ff;

   logic [W:0]    cv;
   logic [W-1:0]  ca [W+1];
   logic [W-1:0]  cs [W+1];

   logic          accept;
   logic          done;
   logic          last_pass;
   logic          first_pass;
   logic          slot_free;
   logic          ebit;
   logic [IW-1:0] bidx;
   logic [W-1:0]  x_acc, x_sq, y_acc, y_sq;
   logic [W-1:0]  final_value;
   logic          mod_small;

   assign accept     = req_valid && req_ready;
   assign done       = cv[W];
   assign first_pass = (pass_ff == '0);
   assign last_pass  = (pass_ff == PW'(W));
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign mod_small  = (modulus_ff < W'(2));
   assign bidx       = IW'(pass_ff - PW'(1));
   assign ebit       = !first_pass && exponent_ff[bidx];

   always_comb begin
      x_acc = ebit ? sq_ff : W'(1);
      y_acc = acc_ff;
      x_sq  = first_pass ? W'(1) : sq_ff;
      y_sq  = first_pass ? base_ff : sq_ff;
      final_value = mod_small ? '0 : ca[W];
   end

   assign cv[0] = launch_ff;
   assign ca[0] = '0;
   assign cs[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_cell
      mexp_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_acc    (ca[k]),
         .in_sq     (cs[k]),
         .x_acc     (x_acc),
         .x_sq      (x_sq),
         .bit_acc   (y_acc[W-1-k]),
         .bit_sq    (y_sq[W-1-k]),
         .modulus   (modulus_ff),
         .out_valid (cv[k+1]),
         .out_acc   (ca[k+1]),
         .out_sq    (cs[k+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = mexp_pkg::ST_RUN;
            end
         end
         mexp_pkg::ST_RUN: begin
            if (done && last_pass) begin
               state_in = slot_free ? mexp_pkg::ST_IDLE : mexp_pkg::ST_HOLD;
            end
         end
         mexp_pkg::ST_HOLD: begin
            if (slot_free) begin
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == mexp_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         exponent_ff  <= W'(1);
         modulus_ff   <= '1;
         pass_ff      <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               mexp_pkg::CSR_EXPONENT: exponent_ff <= csr_wdata;
               mexp_pkg::CSR_MODULUS:  modulus_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            pass_ff   <= '0;
            launch_ff <= 1'b1;
         end
         if (state_ff == mexp_pkg::ST_RUN && done) begin
            if (last_pass) begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
               end
            end else begin
               pass_ff   <= pass_ff + PW'(1);
               launch_ff <= 1'b1;
            end
         end
         if (state_ff == mexp_pkg::ST_HOLD && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff <= req_base_value;
      end
      if (state_ff == mexp_pkg::ST_RUN && done) begin
         sq_ff <= cs[W];
         if (first_pass) begin
            acc_ff <= W'(1);
         end else if (last_pass) begin
            acc_ff <= final_value;
            if (slot_free) begin
               rsp_data_ff <= final_value;
            end
         end else begin
            acc_ff <= ca[W];
         end
      end
      if (state_ff == mexp_pkg::ST_HOLD && slot_free) begin
         rsp_data_ff <= acc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

`ifndef SYNTHESIS
   a_chain_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cv))
      else $error("more than one multiply in flight on the cell chain");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == mexp_pkg::ST_RUN && launch_ff)
      else $error("accepted request did not start the chain");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_data_ff < modulus_ff || mod_small)
      else $error("result not reduced below the modulus");

   a_no_launch_idle: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> state_ff == mexp_pkg::ST_RUN)
      else $error("chain launched outside a run");
`endif

endmodule

@@ hw/rtl/mexp_cell.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation multiplier cell
// One step of an interleaved modular multiply for two lanes: doubles the
// partial remainder, adds the multiplicand where the multiplier bit is set,
// and reduces after each addition.
// ----------------------------------------------------------------------------
module mexp_cell #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [W-1:0] in_acc,
   input  logic [W-1:0] in_sq,
   input  logic [W-1:0] x_acc,
   input  logic [W-1:0] x_sq,
   input  logic         bit_acc,
   input  logic         bit_sq,
   input  logic [W-1:0] modulus,
   output logic         out_valid,
   output logic [W-1:0] out_acc,
   output logic [W-1:0] out_sq
);

   logic         valid_ff;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] sq_ff, sq_in;

   function automatic logic [W-1:0] mod_step(
      input logic [W-1:0] r,
      input logic [W-1:0] x,
      input logic         b,
      input logic [W-1:0] m
   );
      logic [W:0] t;
      logic [W:0] mw;
      mw = {1'b0, m};
      t  = {r, 1'b0};
      if (t >= mw) begin
         t = t - mw;
      end
      if (b) begin
         t = t + {1'b0, x};
      end
      if (t >= mw) begin
         t = t - mw;
      end
      return t[W-1:0];
   endfunction

   always_comb begin
      acc_in = mod_step(in_acc, x_acc, bit_acc, modulus);
      sq_in  = mod_step(in_sq, x_sq, bit_sq, modulus);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_sq    = sq_ff;

endmodule

@@ test/tb_modular_exponentiation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives bases through the request channel under several exponent and modulus
// settings and checks every response against a square and multiply predictor.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

   localparam int W = 16;

   class power_scoreboard;
      logic [W-1:0] expected_powers[$];
      logic [W-1:0] exponent_value;
      logic [W-1:0] modulus_value;
      int error_count;

      function new();
         exponent_value = W'(1);
         modulus_value = 16'hFFFF;
         error_count = 0;
      endfunction

      function logic [W-1:0] power_mod(logic [W-1:0] base);
         logic [63:0] acc;
         logic [63:0] sq;
         logic [63:0] m;
         m = 64'(modulus_value);
         if (m < 64'd2) return '0;
         acc = 64'd1 % m;
         sq = 64'(base) % m;
         for (int i = 0; i < W; i++) begin
            if (exponent_value[i]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
         end
         return acc[W-1:0];
      endfunction

      function void note_request(logic [W-1:0] base);
         expected_powers = {expected_powers, power_mod(base)};
      endfunction

      function void check_response(logic [W-1:0] actual);
         logic [W-1:0] want;
         if (expected_powers.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d", $time, actual);
            error_count++;
            return;
         end
         want = expected_powers.pop_front();
         if (want !== actual) begin
            $display("%0t: power_result mismatch, expected %0d, actual %0d",
                     $time, want, actual);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [W-1:0] req_base_value = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [W-1:0] rsp_power_result;
   logic csr_write = 0;
   logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = mexp_pkg::CSR_EXPONENT;
   logic [W-1:0] csr_wdata = '0;

   int send_idle_pct = 12;
   int recv_idle_pct = 68;
   power_scoreboard board = new();

   modular_exponentiation #(.VALUE_WIDTH(W)) uut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_power_result);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_config(logic [W-1:0] e, logic [W-1:0] m);
      csr_write <= 1'b1;
      csr_index <= mexp_pkg::CSR_EXPONENT;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= mexp_pkg::CSR_MODULUS;
      csr_wdata <= m;
      @(posedge clock);
      csr_write <= 1'b0;
      board.exponent_value = e;
      board.modulus_value = m;
   endtask

   task automatic send_base(logic [W-1:0] base);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base_value <= base;
      do @(posedge clock); while (!req_ready);
      board.note_request(base);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (board.expected_powers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_and_run(logic [W-1:0] e, logic [W-1:0] m, int count);
      drain();
      write_config(e, m);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(7))
            0: send_base('0);
            1: send_base('1);
            2: send_base(m);
            default: send_base(W'($urandom));
         endcase
      end
   endtask

   initial begin
      logic [W-1:0] dir_bases[7] = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF,
                                    16'hFFFE, 16'h8000, 16'h5A5A};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir_bases[i]) send_base(dir_bases[i]);
      set_and_run(16'd0, 16'd2, 4);
      set_and_run(16'hFFFF, 16'hFFFF, 4);
      set_and_run(16'h8000, 16'd3233, 4);
      set_and_run(16'd17, 16'd1, 3);
      set_and_run(16'd5, 16'd0, 3);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 68;
            recv_idle_pct = 12;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int s = 0; s < 4; s++)
            set_and_run(W'($urandom), W'($urandom_range(65535, 2)), 42);
      end
      drain();
      if (board.error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #(12ns * 1200000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
